[rtl/core/plc_pkg.sv]
// ----------------------------------------------------------------------------
// plc_pkg
// Types and constants shared by the PIN lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

	localparam int PIN_LENGTH = 5;
	localparam int DIG_W      = 3;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;

	localparam logic [DIG_W-1:0] PIN_LAST = DIG_W'(PIN_LENGTH);

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_CW_UNTIL    = 3'd0;
	localparam logic [2:0] REG_PAUSE_UNTIL = 3'd1;
	localparam logic [2:0] REG_ACW_UNTIL   = 3'd2;
	localparam logic [2:0] REG_ALARM_TICKS = 3'd3;
	localparam logic [2:0] REG_MAX_WRONG   = 3'd4;

	// reset values of the registers
	localparam logic [7:0] CW_UNTIL_RST    = 8'd15;
	localparam logic [7:0] PAUSE_UNTIL_RST = 8'd18;
	localparam logic [7:0] ACW_UNTIL_RST   = 8'd33;
	localparam logic [7:0] ALARM_TICKS_RST = 8'd60;
	localparam logic [2:0] MAX_WRONG_RST   = 3'd3;

	// characters and reply bytes
	localparam logic [7:0] OPEN_CHAR   = 8'h2B;
	localparam logic [7:0] CHANGE_CHAR = 8'h2D;
	localparam logic [7:0] READY_BYTE  = 8'h31;
	localparam logic [7:0] PIN_GOOD    = 8'h00;
	localparam logic [7:0] PIN_WRONG   = 8'h01;

	// request kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// motor drive codes
	localparam logic [1:0] MOTOR_STOP = 2'd0;
	localparam logic [1:0] MOTOR_CW   = 2'd1;
	localparam logic [1:0] MOTOR_ACW  = 2'd2;

	// lock mode codes as seen on the result
	localparam logic [2:0] LOCK_ENROLL = 3'd0;
	localparam logic [2:0] LOCK_IDLE   = 3'd1;
	localparam logic [2:0] LOCK_VERIFY = 3'd2;
	localparam logic [2:0] LOCK_OPEN   = 3'd3;
	localparam logic [2:0] LOCK_ALARM  = 3'd4;

	typedef enum logic [4:0] {
		MODE_ENROLL = 5'b00001,
		MODE_IDLE   = 5'b00010,
		MODE_VERIFY = 5'b00100,
		MODE_OPEN   = 5'b01000,
		MODE_ALARM  = 5'b10000
	} mode_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [1:0] motor_drive;
		logic       siren_on;
		logic [2:0] lock_mode;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

[rtl/core/pin_lock_controller.sv]
// ----------------------------------------------------------------------------
// pin_lock_controller
// Combination lock control: PIN enrolment, verification, motor and alarm.
// ----------------------------------------------------------------------------
// Each item (a received byte or a one-second tick) is captured in an input
// register, processed combinationally once the output register is free, and
// its result is then registered in the output register. A good PIN change
// gives two results (0 then 0x31); the second one is held in a spare register
// and the input stalls while it is pending. Otherwise one item is taken every
// clock cycle, limited only by the output stall. The first PIN_LENGTH bytes
// after reset enrol the PIN. The user must write the registers over the APB
// port only while the block is idle; the block itself does not enforce it.
`default_nettype none

module pin_lock_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire plc_pkg::item_t                  item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output plc_pkg::result_t                     result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [plc_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [plc_pkg::PDATA_W-1:0]     pwdata,
	output logic [plc_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready
);

	// configuration
	logic [7:0] cw_until_q, pause_until_q, acw_until_q, alarm_ticks_q;
	logic [2:0] max_wrong_q;
	logic       cfg_wr;
	logic [2:0] cfg_idx;

	// input stage
	logic             item_valid_s1;
	plc_pkg::item_t   item_s1;

	// lock state
	plc_pkg::mode_t            mode_q, mode_d;
	logic [7:0]                pin_q [plc_pkg::PIN_LENGTH];
	logic [plc_pkg::DIG_W-1:0] digit_q, digit_d;
	logic                      mismatch_q, mismatch_d;
	logic [2:0]                attempt_q, attempt_d;
	logic [7:0]                tick_q, tick_d;
	logic                      change_q, change_d;
	logic [1:0]                motor_q, motor_d;
	logic                      buzzer_q, buzzer_d;

	// processing
	logic                      fire;
	logic                      out_free;
	logic [plc_pkg::DIG_W-1:0] idx;
	logic [plc_pkg::DIG_W-1:0] idx_next;
	logic [7:0]                tick_inc;
	logic                      bad;
	logic                      pin_wr;
	logic                      two_res;
	logic                      res_tx_valid;
	logic [7:0]                res_tx_byte;
	logic                      res_last;
	logic [2:0]                lock_code;
	plc_pkg::result_t          res0, res1;

	// output side
	logic             pend_valid_q;
	plc_pkg::result_t pend_q;
	plc_pkg::result_t result_q;
	logic             result_valid_q;

	// ---------------------------------------------------------------- apb
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_until_q    <= plc_pkg::CW_UNTIL_RST;
			pause_until_q <= plc_pkg::PAUSE_UNTIL_RST;
			acw_until_q   <= plc_pkg::ACW_UNTIL_RST;
			alarm_ticks_q <= plc_pkg::ALARM_TICKS_RST;
			max_wrong_q   <= plc_pkg::MAX_WRONG_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				plc_pkg::REG_CW_UNTIL:    cw_until_q    <= pwdata[7:0];
				plc_pkg::REG_PAUSE_UNTIL: pause_until_q <= pwdata[7:0];
				plc_pkg::REG_ACW_UNTIL:   acw_until_q   <= pwdata[7:0];
				plc_pkg::REG_ALARM_TICKS: alarm_ticks_q <= pwdata[7:0];
				plc_pkg::REG_MAX_WRONG:   max_wrong_q   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			plc_pkg::REG_CW_UNTIL:    prdata = {24'd0, cw_until_q};
			plc_pkg::REG_PAUSE_UNTIL: prdata = {24'd0, pause_until_q};
			plc_pkg::REG_ACW_UNTIL:   prdata = {24'd0, acw_until_q};
			plc_pkg::REG_ALARM_TICKS: prdata = {24'd0, alarm_ticks_q};
			plc_pkg::REG_MAX_WRONG:   prdata = {29'd0, max_wrong_q};
			default:                  prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- handshake
	assign out_free   = !result_valid_q || !result_stall;
	assign fire       = item_valid_s1 && out_free && !pend_valid_q;
	assign item_stall = item_valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_valid_s1 || fire) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!item_valid_s1 || fire) && item_valid) begin
			item_s1 <= item;
		end
	end

	// ---------------------------------------------------------------- next state
	assign idx      = (digit_q < plc_pkg::PIN_LAST) ? digit_q : '0;
	assign idx_next = idx + 1'b1;
	assign tick_inc = tick_q + 8'd1;
	assign bad      = mismatch_q || (pin_q[idx] != item_s1.rx_byte);

	always_comb begin
		mode_d       = mode_q;
		digit_d      = digit_q;
		mismatch_d   = mismatch_q;
		attempt_d    = attempt_q;
		tick_d       = tick_q;
		change_d     = change_q;
		motor_d      = motor_q;
		buzzer_d     = buzzer_q;
		pin_wr       = 1'b0;
		two_res      = 1'b0;
		res_tx_valid = 1'b0;
		res_tx_byte  = plc_pkg::PIN_GOOD;
		res_last     = 1'b1;

		if (item_s1.req_type == plc_pkg::REQ_TICK) begin
			case (mode_q)
				plc_pkg::MODE_OPEN: begin
					tick_d = tick_inc;
					// end threshold wins over the others
					if (tick_inc == acw_until_q) begin
						tick_d  = '0;
						motor_d = plc_pkg::MOTOR_STOP;
						mode_d  = plc_pkg::MODE_IDLE;
					end else if (tick_inc == 8'd1) begin
						motor_d = plc_pkg::MOTOR_CW;
					end else if (tick_inc == cw_until_q) begin
						motor_d = plc_pkg::MOTOR_STOP;
					end else if (tick_inc == pause_until_q) begin
						motor_d = plc_pkg::MOTOR_ACW;
					end
				end
				plc_pkg::MODE_ALARM: begin
					tick_d = tick_inc;
					if (tick_inc == alarm_ticks_q) begin
						tick_d    = '0;
						buzzer_d  = 1'b0;
						attempt_d = '0;
						mode_d    = plc_pkg::MODE_IDLE;
					end else if (tick_inc == 8'd1) begin
						buzzer_d = 1'b1;
					end
				end
				default: ;
			endcase
		end else begin
			case (mode_q)
				plc_pkg::MODE_ENROLL: begin
					pin_wr  = 1'b1;
					digit_d = idx_next;
					if (idx_next >= plc_pkg::PIN_LAST) begin
						digit_d = '0;
						mode_d  = plc_pkg::MODE_IDLE;
					end
				end
				plc_pkg::MODE_IDLE: begin
					if (item_s1.rx_byte == plc_pkg::OPEN_CHAR ||
					    item_s1.rx_byte == plc_pkg::CHANGE_CHAR) begin
						change_d   = (item_s1.rx_byte == plc_pkg::CHANGE_CHAR);
						digit_d    = '0;
						mismatch_d = 1'b0;
						mode_d     = plc_pkg::MODE_VERIFY;
					end
				end
				plc_pkg::MODE_VERIFY: begin
					if (idx_next >= plc_pkg::PIN_LAST) begin
						digit_d      = '0;
						mismatch_d   = 1'b0;
						res_tx_valid = 1'b1;
						if (bad) begin
							attempt_d   = attempt_q + 3'd1;
							res_tx_byte = plc_pkg::PIN_WRONG;
							if ((attempt_q + 3'd1) >= max_wrong_q) begin
								mode_d = plc_pkg::MODE_ALARM;
								tick_d = '0;
							end
						end else begin
							attempt_d = '0;
							if (change_q) begin
								change_d = 1'b0;
								mode_d   = plc_pkg::MODE_ENROLL;
								two_res  = 1'b1;
								res_last = 1'b0;
							end else begin
								mode_d = plc_pkg::MODE_OPEN;
								tick_d = '0;
							end
						end
					end else begin
						digit_d    = idx_next;
						mismatch_d = bad;
					end
				end
				plc_pkg::MODE_OPEN, plc_pkg::MODE_ALARM: ;
				default: mode_d = plc_pkg::MODE_IDLE;
			endcase
		end
	end

	always_comb begin
		case (mode_d)
			plc_pkg::MODE_ENROLL: lock_code = plc_pkg::LOCK_ENROLL;
			plc_pkg::MODE_IDLE:   lock_code = plc_pkg::LOCK_IDLE;
			plc_pkg::MODE_VERIFY: lock_code = plc_pkg::LOCK_VERIFY;
			plc_pkg::MODE_OPEN:   lock_code = plc_pkg::LOCK_OPEN;
			plc_pkg::MODE_ALARM:  lock_code = plc_pkg::LOCK_ALARM;
			default:              lock_code = plc_pkg::LOCK_IDLE;
		endcase
	end

	always_comb begin
		res0.tx_valid    = res_tx_valid;
		res0.tx_byte     = res_tx_byte;
		res0.motor_drive = motor_d;
		res0.siren_on    = buzzer_d;
		res0.lock_mode   = lock_code;
		res0.last        = res_last;
		res1             = res0;
		res1.tx_byte     = plc_pkg::READY_BYTE;
		res1.last        = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= plc_pkg::MODE_ENROLL;
			digit_q    <= '0;
			mismatch_q <= 1'b0;
			attempt_q  <= '0;
			tick_q     <= '0;
			change_q   <= 1'b0;
			motor_q    <= plc_pkg::MOTOR_STOP;
			buzzer_q   <= 1'b0;
		end else if (fire) begin
			mode_q     <= mode_d;
			digit_q    <= digit_d;
			mismatch_q <= mismatch_d;
			attempt_q  <= attempt_d;
			tick_q     <= tick_d;
			change_q   <= change_d;
			motor_q    <= motor_d;
			buzzer_q   <= buzzer_d;
		end
	end

	// pin digits hold no reset value
	always_ff @(posedge clk) begin
		if (fire && pin_wr) begin
			pin_q[idx] <= item_s1.rx_byte;
		end
	end

	// ---------------------------------------------------------------- results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			pend_valid_q   <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				result_valid_q <= 1'b1;
				pend_valid_q   <= 1'b0;
			end else begin
				result_valid_q <= fire;
				pend_valid_q   <= fire && two_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				result_q <= pend_q;
			end else if (fire) begin
				result_q <= res0;
				pend_q   <= res1;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

[tb/sv/pin_lock_controller_tb.sv]
// ----------------------------------------------------------------------------
// pin_lock_controller_tb
// Self-checking bench for the PIN lock controller. A behavioural model of the
// lock runs beside the block and predicts every reply from each accepted
// byte or tick. The bench walks the lock through enrolment, open and change
// attempts, the motor sequence and the alarm, first by hand and then with
// random traffic over several register settings, with the sender and the
// receiver idling at random and one long receiver hold-off.
// ----------------------------------------------------------------------------

module pin_lock_controller_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          STALL_LIMIT   = 1000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          HOLD_CYCLES   = 150;
	localparam logic [7:0]  NO_BYTE       = 8'h00;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            item_valid = 1'b0;
	logic                            item_stall;
	plc_pkg::item_t                  item = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	plc_pkg::result_t                result;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [plc_pkg::PADDR_W-1:0]     paddr = '0;
	logic [plc_pkg::PDATA_W-1:0]     pwdata = '0;
	logic [plc_pkg::PDATA_W-1:0]     prdata;
	logic                            pready;

	// lock model state
	logic [2:0]            lk_mode;
	logic [7:0]            pin_digits [plc_pkg::PIN_LENGTH];
	logic [2:0]            dig_pos;
	logic                  pin_bad;
	logic [2:0]            fail_count;
	logic [7:0]            sec_count;
	logic                  want_change;
	logic [1:0]            motor;
	logic                  buzzer;

	// register copies
	logic [7:0]            cfg_cw_until;
	logic [7:0]            cfg_pause_until;
	logic [7:0]            cfg_acw_until;
	logic [7:0]            cfg_alarm_ticks;
	logic [2:0]            cfg_max_wrong;

	plc_pkg::result_t      expected_replies [$];
	int unsigned           mismatch_count = 0;
	int unsigned           quiet_cycles = 0;
	int unsigned           gap_pct = 0;
	int unsigned           stall_pct = 0;
	int unsigned           hold_left = 0;
	bit                    aim_good = 1'b1;

	pin_lock_controller u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_reply(logic tv, logic [7:0] tx_code, logic lst);
		plc_pkg::result_t r;
		r.tx_valid    = tv;
		r.tx_byte     = tx_code;
		r.motor_drive = motor;
		r.siren_on    = buzzer;
		r.lock_mode   = lk_mode;
		r.last        = lst;
		expected_replies.push_back(r);
	endfunction

	// advances the lock model by one byte or tick and queues its replies
	task automatic predict_lock_outcome(plc_pkg::item_t it);
		logic [2:0] pos;
		logic       was_bad;
		pos = (dig_pos < plc_pkg::PIN_LENGTH) ? dig_pos : 3'd0;
		if (it.req_type == plc_pkg::REQ_TICK) begin
			if (lk_mode == plc_pkg::LOCK_OPEN) begin
				sec_count = sec_count + 8'd1;
				// end of opening wins over every other threshold
				if (sec_count == cfg_acw_until) begin
					sec_count = 8'd0;
					motor     = plc_pkg::MOTOR_STOP;
					lk_mode   = plc_pkg::LOCK_IDLE;
				end else if (sec_count == 8'd1) begin
					motor = plc_pkg::MOTOR_CW;
				end else if (sec_count == cfg_cw_until) begin
					motor = plc_pkg::MOTOR_STOP;
				end else if (sec_count == cfg_pause_until) begin
					motor = plc_pkg::MOTOR_ACW;
				end
			end else if (lk_mode == plc_pkg::LOCK_ALARM) begin
				sec_count = sec_count + 8'd1;
				if (sec_count == cfg_alarm_ticks) begin
					sec_count  = 8'd0;
					buzzer     = 1'b0;
					fail_count = 3'd0;
					lk_mode    = plc_pkg::LOCK_IDLE;
				end else if (sec_count == 8'd1) begin
					buzzer = 1'b1;
				end
			end
			push_reply(1'b0, NO_BYTE, 1'b1);
			return;
		end
		case (lk_mode)
			plc_pkg::LOCK_ENROLL: begin
				pin_digits[pos] = it.rx_byte;
				dig_pos = pos + 3'd1;
				if (dig_pos >= plc_pkg::PIN_LENGTH) begin
					dig_pos = 3'd0;
					lk_mode = plc_pkg::LOCK_IDLE;
				end
			end
			plc_pkg::LOCK_IDLE: begin
				if (it.rx_byte == plc_pkg::OPEN_CHAR || it.rx_byte == plc_pkg::CHANGE_CHAR) begin
					want_change = (it.rx_byte == plc_pkg::CHANGE_CHAR);
					dig_pos     = 3'd0;
					pin_bad     = 1'b0;
					lk_mode     = plc_pkg::LOCK_VERIFY;
				end
			end
			plc_pkg::LOCK_VERIFY: begin
				if (pin_digits[pos] != it.rx_byte)
					pin_bad = 1'b1;
				dig_pos = pos + 3'd1;
				if (dig_pos >= plc_pkg::PIN_LENGTH) begin
					was_bad = pin_bad;
					dig_pos = 3'd0;
					pin_bad = 1'b0;
					if (was_bad) begin
						fail_count = fail_count + 3'd1;
						if (fail_count >= cfg_max_wrong) begin
							lk_mode   = plc_pkg::LOCK_ALARM;
							sec_count = 8'd0;
						end
						push_reply(1'b1, plc_pkg::PIN_WRONG, 1'b1);
						return;
					end
					fail_count = 3'd0;
					if (want_change) begin
						want_change = 1'b0;
						lk_mode     = plc_pkg::LOCK_ENROLL;
						push_reply(1'b1, plc_pkg::PIN_GOOD, 1'b0);
						push_reply(1'b1, plc_pkg::READY_BYTE, 1'b1);
						return;
					end
					lk_mode   = plc_pkg::LOCK_OPEN;
					sec_count = 8'd0;
					push_reply(1'b1, plc_pkg::PIN_GOOD, 1'b1);
					return;
				end
			end
			plc_pkg::LOCK_OPEN, plc_pkg::LOCK_ALARM: ;
			default: lk_mode = plc_pkg::LOCK_IDLE;
		endcase
		push_reply(1'b0, NO_BYTE, 1'b1);
	endtask

	function automatic plc_pkg::item_t byte_item(logic [7:0] b);
		plc_pkg::item_t it;
		it.req_type = plc_pkg::REQ_BYTE;
		it.rx_byte  = b;
		return it;
	endfunction

	function automatic plc_pkg::item_t tick_item();
		plc_pkg::item_t it;
		it.req_type = plc_pkg::REQ_TICK;
		it.rx_byte  = 8'($urandom);
		return it;
	endfunction

	task automatic send_item(plc_pkg::item_t it);
		int unsigned pause_len;
		pause_len = 0;
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		predict_lock_outcome(it);
		while (pause_len < 16 && $urandom_range(99) < gap_pct)
			pause_len++;
		if (pause_len != 0) begin
			item_valid <= 1'b0;
			repeat (pause_len) @(posedge clk);
		end
	endtask

	task automatic set_idling(idling_t how);
		case (how)
			IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin gap_pct = 46; stall_pct = 0;  end
			IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 46; end
			IDLE_BOTH:     begin gap_pct = 31; stall_pct = 31; end
		endcase
	endtask

	task automatic wait_quiet();
		item_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] value);
		logic [plc_pkg::PDATA_W-1:0] readback;
		logic [plc_pkg::PDATA_W-1:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= plc_pkg::PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		want = plc_pkg::PDATA_W'(value);
		case (idx)
			plc_pkg::REG_CW_UNTIL:    cfg_cw_until    = value;
			plc_pkg::REG_PAUSE_UNTIL: cfg_pause_until = value;
			plc_pkg::REG_ACW_UNTIL:   cfg_acw_until   = value;
			plc_pkg::REG_ALARM_TICKS: cfg_alarm_ticks = value;
			plc_pkg::REG_MAX_WRONG: begin
				cfg_max_wrong = value[2:0];
				want = plc_pkg::PDATA_W'(value[2:0]);
			end
			default: ;
		endcase
		if (readback !== want) begin
			$display("%0t: register %0d expected %0h actual %0h", $time, idx, want, readback);
			mismatch_count++;
		end
		// the bus idles before the next transfer
		@(posedge clk);
	endtask

	task automatic configure(logic [7:0] cw, logic [7:0] pause, logic [7:0] acw,
			logic [7:0] alarm, logic [2:0] max_wrong);
		wait_quiet();
		write_reg(plc_pkg::REG_CW_UNTIL, cw);
		write_reg(plc_pkg::REG_PAUSE_UNTIL, pause);
		write_reg(plc_pkg::REG_ACW_UNTIL, acw);
		write_reg(plc_pkg::REG_ALARM_TICKS, alarm);
		write_reg(plc_pkg::REG_MAX_WRONG, {5'd0, max_wrong});
	endtask

	task automatic reset_block();
		lk_mode         = plc_pkg::LOCK_ENROLL;
		foreach (pin_digits[i])
			pin_digits[i] = 8'h00;
		dig_pos         = 3'd0;
		pin_bad         = 1'b0;
		fail_count      = 3'd0;
		sec_count       = 8'd0;
		want_change     = 1'b0;
		motor           = plc_pkg::MOTOR_STOP;
		buzzer          = 1'b0;
		cfg_cw_until    = plc_pkg::CW_UNTIL_RST;
		cfg_pause_until = plc_pkg::PAUSE_UNTIL_RST;
		cfg_acw_until   = plc_pkg::ACW_UNTIL_RST;
		cfg_alarm_ticks = plc_pkg::ALARM_TICKS_RST;
		cfg_max_wrong   = plc_pkg::MAX_WRONG_RST;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// picks the next byte or tick from where the lock model stands, so most
	// traffic is well-formed attempts with the odd stray byte or tick
	task automatic choose_item(int unsigned good_pct, output plc_pkg::item_t it);
		int unsigned r;
		r  = $urandom_range(99);
		it = byte_item(8'($urandom));
		case (lk_mode)
			plc_pkg::LOCK_ENROLL: if (r < 8) it = tick_item();
			plc_pkg::LOCK_IDLE: begin
				if (r < 60) begin
					it.rx_byte = (r < 35) ? plc_pkg::OPEN_CHAR : plc_pkg::CHANGE_CHAR;
					aim_good   = ($urandom_range(99) < good_pct);
				end else if (r < 80) begin
					it = tick_item();
				end
			end
			plc_pkg::LOCK_VERIFY: begin
				if (r < 4)
					it = tick_item();
				else if (aim_good || r < 50)
					it.rx_byte = pin_digits[dig_pos];
			end
			default: if (r < 90) it = tick_item();
		endcase
	endtask

	task automatic test_directed_walk();
		logic [7:0] enrol_digits [plc_pkg::PIN_LENGTH];
		enrol_digits = '{8'h00, 8'hFF, plc_pkg::OPEN_CHAR, plc_pkg::CHANGE_CHAR, 8'h80};
		foreach (enrol_digits[i])
			send_item(byte_item(enrol_digits[i]));
		// ticks outside opening and alarm, and stray bytes in idle, do nothing
		send_item(tick_item());
		send_item(byte_item(8'h55));
		send_item(tick_item());
		send_item(byte_item(plc_pkg::OPEN_CHAR));
		foreach (enrol_digits[i])
			send_item(byte_item(enrol_digits[i]));
		send_item(byte_item(plc_pkg::OPEN_CHAR));
		repeat (4) send_item(tick_item());
		// one wrong digit on a change with a single attempt allowed
		send_item(byte_item(plc_pkg::CHANGE_CHAR));
		foreach (enrol_digits[i])
			send_item(byte_item((i == 2) ? enrol_digits[i] ^ 8'h01 : enrol_digits[i]));
		send_item(byte_item(8'hAA));
		repeat (2) send_item(tick_item());
	endtask

	task automatic test_random_traffic(int unsigned n, int unsigned good_pct);
		plc_pkg::item_t it;
		repeat (n) begin
			choose_item(good_pct, it);
			send_item(it);
		end
	endtask

	task automatic test_full_pressure();
		plc_pkg::item_t it;
		hold_left = HOLD_CYCLES;
		repeat (60) begin
			choose_item(60, it);
			send_item(it);
		end
	endtask

	// result checker
	task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : reply_checker
		plc_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: reply with nothing expected, expected none actual %0h",
					$time, result);
				mismatch_count++;
			end else begin
				want = expected_replies.pop_front();
				check_field("tx_valid", 8'(want.tx_valid), 8'(result.tx_valid));
				check_field("tx_byte", want.tx_byte, result.tx_byte);
				check_field("motor_drive", 8'(want.motor_drive), 8'(result.motor_drive));
				check_field("siren_on", 8'(want.siren_on), 8'(result.siren_on));
				check_field("lock_mode", 8'(want.lock_mode), 8'(result.lock_mode));
				check_field("last", 8'(want.last), 8'(result.last));
			end
		end
	end

	// receiver stall, with the long hold-off counted down here
	always @(posedge clk) begin : receiver_stall
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		reset_block();
		set_idling(IDLE_NONE);
		configure(8'd2, 8'd3, 8'd4, 8'd2, 3'd1);
		test_directed_walk();

		configure(plc_pkg::CW_UNTIL_RST, plc_pkg::PAUSE_UNTIL_RST, plc_pkg::ACW_UNTIL_RST,
			plc_pkg::ALARM_TICKS_RST, plc_pkg::MAX_WRONG_RST);
		test_random_traffic(200, 60);

		set_idling(IDLE_SENDER);
		configure(8'd2, 8'd3, 8'd4, 8'd2, 3'd1);
		test_random_traffic(200, 50);

		// thresholds out of order, many wrong attempts to reach the top count
		set_idling(IDLE_RECEIVER);
		configure(8'd200, 8'd9, 8'd30, 8'd5, 3'd7);
		test_random_traffic(200, 15);

		set_idling(IDLE_BOTH);
		configure(8'd255, 8'd255, 8'd255, 8'd255, 3'd7);
		test_random_traffic(200, 60);

		// zero attempts allowed: first failure raises the alarm
		configure(8'd5, 8'd10, 8'd20, 8'd3, 3'd0);
		test_random_traffic(100, 40);

		set_idling(IDLE_NONE);
		test_full_pressure();

		wait_quiet();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
